// File: design/rau_pkg.sv
// ============================================================================
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operand widths, operation codes, controller states, and the command and
// status structs that pass between the controller and the datapath.
// ============================================================================
package rau_pkg;

   // Operand widths. Denominators are one bit narrower than numerators.
   localparam int IN_WIDTH      = 16;
   localparam int DEN_WIDTH     = IN_WIDTH - 1;
   localparam int CMD_WIDTH     = 3;
   // Multiplier operands carry one extra bit so a denominator enters as signed.
   localparam int OPND_WIDTH    = IN_WIDTH + 1;
   // Signed cross products, sums and unreduced numerators.
   localparam int PROD_WIDTH    = 2 * IN_WIDTH;
   // Magnitudes of numerators and denominators before reduction.
   localparam int MAG_WIDTH     = 2 * IN_WIDTH - 1;
   localparam int CNT_WIDTH     = $clog2(MAG_WIDTH);
   localparam int RES_NUM_WIDTH = 32;
   localparam int RES_DEN_WIDTH = 31;

   // Operation codes. The codes above CMD_CMP act as compare only.
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ADD = CMD_WIDTH'(0),
      CMD_SUB = CMD_WIDTH'(1),
      CMD_MUL = CMD_WIDTH'(2),
      CMD_DIV = CMD_WIDTH'(3),
      CMD_CMP = CMD_WIDTH'(4)
   } cmd_type;

   // Product slot written by the shared multiplier, in issue order.
   typedef enum logic [1:0] {
      MUL_L  = 2'd0,  // a_num * b_den
      MUL_R  = 2'd1,  // b_num * a_den
      MUL_NN = 2'd2,  // a_num * b_num
      MUL_DD = 2'd3   // a_den * b_den
   } mul_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FORM,
      ST_PREP,
      ST_GCD,
      ST_DIV,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        form;
      logic        prep;
      logic        gcd_step;
      logic        div_load;
      logic        div_step;
      logic        out_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic reduce;
      logic gcd_done;
   } dp_status_type;

   // Sign-extend or wrap a numerator into the result field.
   function automatic logic [RES_NUM_WIDTH-1:0] fit_num(
      input logic signed [PROD_WIDTH-1:0] v);
      logic signed [63:0] wide;
      wide = 64'(v);
      return wide[RES_NUM_WIDTH-1:0];
   endfunction

   // Zero-extend or wrap a denominator into the result field.
   function automatic logic [RES_DEN_WIDTH-1:0] fit_den(
      input logic [MAG_WIDTH-1:0] d);
      logic [63:0] wide;
      wide = 64'(d);
      return wide[RES_DEN_WIDTH-1:0];
   endfunction

endpackage

// File: design/rau_datapath.sv
// ============================================================================
// rau_datapath: operand registers, shared multiplier, gcd and divider
// Holds one transaction's operands, forms the unreduced fraction and flags,
// runs binary gcd on the magnitudes and divides both parts by the odd gcd
// factor with two restoring dividers that step together.
// ============================================================================
module rau_datapath import rau_pkg::*; (
   input  logic                            clock,
   input  ctrl_cmd_type                    ctrl,
   output dp_status_type                   status,
   input  logic [CMD_WIDTH-1:0]            req_cmd,
   input  logic signed [IN_WIDTH-1:0]      req_a_num,
   input  logic [DEN_WIDTH-1:0]            req_a_den,
   input  logic signed [IN_WIDTH-1:0]      req_b_num,
   input  logic [DEN_WIDTH-1:0]            req_b_den,
   output logic signed [RES_NUM_WIDTH-1:0] rsp_res_num,
   output logic [RES_DEN_WIDTH-1:0]        rsp_res_den,
   output logic                            rsp_is_less,
   output logic                            rsp_is_equal,
   output logic                            rsp_is_greater,
   output logic                            rsp_error
);

   // One restoring division step: shift in the next dividend bit, subtract
   // the divisor when it fits. Returns {remainder, quotient}.
   function automatic logic [2*MAG_WIDTH-1:0] div_bit(
      input logic [MAG_WIDTH-1:0] rem,
      input logic [MAG_WIDTH-1:0] quo,
      input logic [MAG_WIDTH-1:0] divisor);
      logic [MAG_WIDTH:0]   rem_sh;
      logic [MAG_WIDTH:0]   rem_sub;
      logic                 fits;
      rem_sh  = {rem, quo[MAG_WIDTH-1]};
      rem_sub = rem_sh - {1'b0, divisor};
      fits    = rem_sh >= {1'b0, divisor};
      return {fits ? rem_sub[MAG_WIDTH-1:0] : rem_sh[MAG_WIDTH-1:0],
              quo[MAG_WIDTH-2:0], fits};
   endfunction

   // Operand registers.
   cmd_type                      cmd_ff;
   logic signed [IN_WIDTH-1:0]   a_num_ff, b_num_ff;
   logic [DEN_WIDTH-1:0]         a_den_ff, b_den_ff;

   // Products.
   logic signed [PROD_WIDTH-1:0] l_ff, r_ff, nn_ff, dd_ff;

   // Unreduced result and flags.
   logic signed [PROD_WIDTH-1:0] num_ff, num_in;
   logic [MAG_WIDTH-1:0]         den_ff, den_in;
   logic                         err_ff, err_in;
   logic                         lt_ff, lt_in, eq_ff, eq_in, gt_ff, gt_in;

   // Reduction state.
   logic                         sign_ff;
   logic [MAG_WIDTH-1:0]         u_ff, u_in, v_ff, v_in;
   logic [MAG_WIDTH-1:0]         nx_ff, nx_in, dy_ff, dy_in;
   logic [MAG_WIDTH-1:0]         q_num_ff, q_den_ff;
   logic [MAG_WIDTH-1:0]         rem_num_ff, rem_den_ff;

   // Output register.
   logic signed [RES_NUM_WIDTH-1:0] res_num_ff;
   logic [RES_DEN_WIDTH-1:0]        res_den_ff;
   logic                            res_lt_ff, res_eq_ff, res_gt_ff, res_err_ff;

   logic signed [OPND_WIDTH-1:0]   mul_x, mul_y;
   logic signed [2*OPND_WIDTH-1:0] mul_p;
   logic signed [PROD_WIDTH-1:0]   mul_q;
   logic                           den_zero, r_neg;
   logic signed [PROD_WIDTH-1:0]   r_abs, num_abs, q_signed;
   logic [MAG_WIDTH-1:0]           mag_v;
   logic                           is_arith;
   logic [2*MAG_WIDTH-1:0]         div_num_v, div_den_v;

   // Capture the operands of an accepted transaction.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff   <= cmd_type'(req_cmd);
         a_num_ff <= req_a_num;
         a_den_ff <= req_a_den;
         b_num_ff <= req_b_num;
         b_den_ff <= req_b_den;
      end
   end

   // Shared multiplier: the controller picks one product per cycle.
   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_L: begin
            mul_x = OPND_WIDTH'(a_num_ff);
            mul_y = $signed({2'b00, b_den_ff});
         end
         MUL_R: begin
            mul_x = OPND_WIDTH'(b_num_ff);
            mul_y = $signed({2'b00, a_den_ff});
         end
         MUL_NN: begin
            mul_x = OPND_WIDTH'(a_num_ff);
            mul_y = OPND_WIDTH'(b_num_ff);
         end
         MUL_DD: begin
            mul_x = $signed({2'b00, a_den_ff});
            mul_y = $signed({2'b00, b_den_ff});
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
      mul_p = mul_x * mul_y;
      mul_q = $signed(mul_p[PROD_WIDTH-1:0]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         unique case (ctrl.mul_sel)
            MUL_L:   l_ff  <= mul_q;
            MUL_R:   r_ff  <= mul_q;
            MUL_NN:  nn_ff <= mul_q;
            MUL_DD:  dd_ff <= mul_q;
            default: l_ff  <= mul_q;
         endcase
      end
   end

   // Form the unreduced numerator, denominator, flags and error.
   always_comb begin
      den_zero = (a_den_ff == '0) || (b_den_ff == '0);
      r_neg    = r_ff[PROD_WIDTH-1];
      r_abs    = r_neg ? -r_ff : r_ff;
      num_in   = '0;
      den_in   = MAG_WIDTH'(1);
      err_in   = 1'b0;
      lt_in    = 1'b0;
      eq_in    = 1'b0;
      gt_in    = 1'b0;
      if (den_zero) begin
         err_in = 1'b1;
         den_in = '0;
      end else begin
         lt_in = l_ff < r_ff;
         eq_in = l_ff == r_ff;
         gt_in = l_ff > r_ff;
         unique case (cmd_ff)
            CMD_ADD: begin
               num_in = l_ff + r_ff;
               den_in = dd_ff[MAG_WIDTH-1:0];
            end
            CMD_SUB: begin
               num_in = l_ff - r_ff;
               den_in = dd_ff[MAG_WIDTH-1:0];
            end
            CMD_MUL: begin
               num_in = nn_ff;
               den_in = dd_ff[MAG_WIDTH-1:0];
            end
            CMD_DIV: begin
               if (b_num_ff == '0) begin
                  err_in = 1'b1;
                  den_in = '0;
               end else begin
                  num_in = r_neg ? -l_ff : l_ff;
                  den_in = r_abs[MAG_WIDTH-1:0];
               end
            end
            default: begin
               num_in = '0;
               den_in = MAG_WIDTH'(1);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.form) begin
         num_ff <= num_in;
         den_ff <= den_in;
         err_ff <= err_in;
         lt_ff  <= lt_in;
         eq_ff  <= eq_in;
         gt_ff  <= gt_in;
      end
   end

   // Decide whether the fraction needs reduction and take its magnitude.
   always_comb begin
      num_abs  = num_ff[PROD_WIDTH-1] ? -num_ff : num_ff;
      mag_v    = num_abs[MAG_WIDTH-1:0];
      is_arith = (cmd_ff == CMD_ADD) || (cmd_ff == CMD_SUB) ||
                 (cmd_ff == CMD_MUL) || (cmd_ff == CMD_DIV);
      status.reduce   = !err_ff && is_arith && (num_ff != '0);
      status.gcd_done = u_ff == v_ff;
   end

   // Binary gcd step. Common factors of two are stripped from the working
   // pair and from the copies to be divided, so only the odd part remains.
   always_comb begin
      u_in  = u_ff;
      v_in  = v_ff;
      nx_in = nx_ff;
      dy_in = dy_ff;
      priority if (!u_ff[0] && !v_ff[0]) begin
         u_in  = u_ff >> 1;
         v_in  = v_ff >> 1;
         nx_in = nx_ff >> 1;
         dy_in = dy_ff >> 1;
      end else if (!u_ff[0]) begin
         u_in = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_in = v_ff >> 1;
      end else if (u_ff > v_ff) begin
         u_in = (u_ff - v_ff) >> 1;
      end else begin
         v_in = (v_ff - u_ff) >> 1;
      end
   end

   // Both divisions run side by side with the odd gcd factor as divisor.
   always_comb begin
      div_num_v = div_bit(rem_num_ff, q_num_ff, u_ff);
      div_den_v = div_bit(rem_den_ff, q_den_ff, u_ff);
   end

   // Reduction registers: load, gcd iterations, division steps.
   always_ff @(posedge clock) begin
      if (ctrl.prep) begin
         sign_ff <= status.reduce && num_ff[PROD_WIDTH-1];
         u_ff    <= mag_v;
         v_ff    <= den_ff;
         nx_ff   <= mag_v;
         dy_ff   <= den_ff;
         // Nothing to reduce: zero numerator, compare or error.
         q_num_ff <= '0;
         q_den_ff <= err_ff ? '0 : MAG_WIDTH'(1);
      end else if (ctrl.gcd_step) begin
         u_ff  <= u_in;
         v_ff  <= v_in;
         nx_ff <= nx_in;
         dy_ff <= dy_in;
      end else if (ctrl.div_load) begin
         q_num_ff   <= nx_ff;
         q_den_ff   <= dy_ff;
         rem_num_ff <= '0;
         rem_den_ff <= '0;
      end else if (ctrl.div_step) begin
         rem_num_ff <= div_num_v[2*MAG_WIDTH-1:MAG_WIDTH];
         q_num_ff   <= div_num_v[MAG_WIDTH-1:0];
         rem_den_ff <= div_den_v[2*MAG_WIDTH-1:MAG_WIDTH];
         q_den_ff   <= div_den_v[MAG_WIDTH-1:0];
      end
   end

   // Output register, loaded when the result slot is free.
   assign q_signed = sign_ff ? -$signed({1'b0, q_num_ff}) : $signed({1'b0, q_num_ff});

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         res_num_ff <= $signed(fit_num(q_signed));
         res_den_ff <= fit_den(q_den_ff);
         res_lt_ff  <= lt_ff;
         res_eq_ff  <= eq_ff;
         res_gt_ff  <= gt_ff;
         res_err_ff <= err_ff;
      end
   end

   assign rsp_res_num    = res_num_ff;
   assign rsp_res_den    = res_den_ff;
   assign rsp_is_less    = res_lt_ff;
   assign rsp_is_equal   = res_eq_ff;
   assign rsp_is_greater = res_gt_ff;
   assign rsp_error      = res_err_ff;

endmodule

// File: design/rau_ctrl.sv
// ============================================================================
// rau_ctrl: sequencing controller of the rational arithmetic unit
// Accepts one transaction at a time, steps the datapath through multiply,
// form, gcd and divide phases, and owns the result valid flag.
// ============================================================================
module rau_ctrl import rau_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  ctrl
);

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   // State, step counter and result valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ctrl         = '0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               cnt_in    = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = mul_sel_type'(cnt_ff[1:0]);
            cnt_in       = cnt_ff + CNT_WIDTH'(1);
            if (ctrl.mul_sel == MUL_DD) begin
               state_in = ST_FORM;
            end
         end
         ST_FORM: begin
            ctrl.form = 1'b1;
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            ctrl.prep = 1'b1;
            state_in  = status.reduce ? ST_GCD : ST_DONE;
         end
         ST_GCD: begin
            if (status.gcd_done) begin
               ctrl.div_load = 1'b1;
               cnt_in        = '0;
               state_in      = ST_DIV;
            end else begin
               ctrl.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
            cnt_in        = cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == CNT_WIDTH'(MAG_WIDTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               ctrl.out_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/rational_arith_unit.sv
// ============================================================================
// rational_arith_unit: rational fraction arithmetic with gcd reduction
// Adds, subtracts, multiplies, divides or compares two fractions and returns
// the result reduced to lowest terms with a positive denominator.
// ============================================================================
//
//   Channel   Direction   Handshake                 Payload
//   req       in          req_valid / req_stall     cmd, a_num, a_den, b_num, b_den
//   rsp       out         rsp_valid / rsp_stall     res_num, res_den, flags, error
//
// One transaction is in work at a time. Without reduction (compare, error or
// zero numerator) a result follows the multiply, form and prep steps; with
// reduction the binary gcd steps and the 31 steps of the dividers come between
// the prep step and the result.
// A new transaction is accepted once the result sits in the output register,
// even while rsp_stall holds it. Reset is synchronous and clears control only.
//
module rational_arith_unit import rau_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [CMD_WIDTH-1:0]            req_cmd,
   input  logic signed [IN_WIDTH-1:0]      req_a_num,
   input  logic [DEN_WIDTH-1:0]            req_a_den,
   input  logic signed [IN_WIDTH-1:0]      req_b_num,
   input  logic [DEN_WIDTH-1:0]            req_b_den,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [RES_NUM_WIDTH-1:0] rsp_res_num,
   output logic [RES_DEN_WIDTH-1:0]        rsp_res_den,
   output logic                            rsp_is_less,
   output logic                            rsp_is_equal,
   output logic                            rsp_is_greater,
   output logic                            rsp_error
);

   ctrl_cmd_type  ctrl;
   dp_status_type status;

   // Sequencing controller.
   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   // Arithmetic datapath and output register.
   rau_datapath u_datapath (
      .clock          (clock),
      .ctrl           (ctrl),
      .status         (status),
      .req_cmd        (req_cmd),
      .req_a_num      (req_a_num),
      .req_a_den      (req_a_den),
      .req_b_num      (req_b_num),
      .req_b_den      (req_b_den),
      .rsp_res_num    (rsp_res_num),
      .rsp_res_den    (rsp_res_den),
      .rsp_is_less    (rsp_is_less),
      .rsp_is_equal   (rsp_is_equal),
      .rsp_is_greater (rsp_is_greater),
      .rsp_error      (rsp_error)
   );

   // An accepted transaction keeps the input side busy in the next cycle.
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("input not stalled after accepting a transaction");

   // At most one of the ordering flags is set.
   a_flags_exclusive: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({rsp_is_less, rsp_is_equal, rsp_is_greater}) <= 1)
   ) else $error("more than one ordering flag set");

   // An error result carries a zero fraction.
   a_error_zero: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_res_num == '0 && rsp_res_den == '0)
   ) else $error("error result with nonzero fraction");

   // A result is only produced after the controller was busy.
   a_result_after_work: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall)
   ) else $error("result appeared without a transaction in work");

endmodule
